// File: sv/dtt_pkg.sv
package dtt_pkg;

  localparam int CoordWidthDef = 32;
  localparam int FracBitsDef   = 16;
  localparam int RatioWidth    = 16;
  localparam int RatioFrac     = 16;

  localparam logic [RatioWidth-1:0] RatioReset = 16'd262;

  localparam logic [1:0] Vtx0 = 2'd0;
  localparam logic [1:0] Vtx1 = 2'd1;
  localparam logic [1:0] Vtx2 = 2'd2;

endpackage

// File: sv/dtt_tri_if.sv
interface dtt_tri_if #(
  parameter int CW = 32
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] v0_x;
  logic signed [CW-1:0] v0_y;
  logic signed [CW-1:0] v0_z;
  logic signed [CW-1:0] v1_x;
  logic signed [CW-1:0] v1_y;
  logic signed [CW-1:0] v1_z;
  logic signed [CW-1:0] v2_x;
  logic signed [CW-1:0] v2_y;
  logic signed [CW-1:0] v2_z;

  modport source (
    output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    input  ready
  );
  modport sink (
    input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    output ready
  );
endinterface

// File: sv/dtt_res_if.sv
interface dtt_res_if #(
  parameter int LW = 34
);
  logic          valid;
  logic          ready;
  logic          is_sliver;
  logic [1:0]    short_first;
  logic [1:0]    short_second;
  logic [LW-1:0] longest_edge;

  modport source (
    output valid, is_sliver, short_first, short_second, longest_edge,
    input  ready
  );
  modport sink (
    input  valid, is_sliver, short_first, short_second, longest_edge,
    output ready
  );
endinterface

// File: sv/degenerate_triangle_test.sv
// Pipeline from input transaction to result:
// three stages for differences, squares and sums, one per root bit in the edge
// square root pipeline, five for the area product and the threshold compare.
// Throughput: one triangle per cycle; a stalled output holds the whole pipeline.
// Reset clears the valid line and loads the threshold register with 262.
module degenerate_triangle_test
  import dtt_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidthDef,
  parameter int FRAC_BITS   = FracBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RatioWidth-1:0] cfg_wdata_i,
  dtt_tri_if.sink               in_i,
  dtt_res_if.source             out_o
);

  localparam int CW    = COORD_WIDTH;
  localparam int RW    = CW + 2;
  localparam int SW    = 2 * CW + 2;
  localparam int DEPTH = 3 + RW + 5;

  logic [RatioWidth-1:0] ratio_q;
  logic [DEPTH-1:0]      vld_q;
  logic                  en;

  assign en          = !vld_q[DEPTH-1] || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RatioReset;
    end else if (cfg_we_i) begin
      ratio_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_i.valid};
    end
  end

  logic signed [CW-1:0] crd [9];
  logic [CW-1:0]        dif_d [9];
  logic [CW-1:0]        dif_q [9];
  logic [2*CW-1:0]      sq_q  [9];
  logic [SW-1:0]        rad_q [3];
  logic [RW-1:0]        len   [3];

  assign crd[0] = in_i.v0_x;
  assign crd[1] = in_i.v0_y;
  assign crd[2] = in_i.v0_z;
  assign crd[3] = in_i.v1_x;
  assign crd[4] = in_i.v1_y;
  assign crd[5] = in_i.v1_z;
  assign crd[6] = in_i.v2_x;
  assign crd[7] = in_i.v2_y;
  assign crd[8] = in_i.v2_z;

  for (genvar e = 0; e < 3; e++) begin : g_edge
    for (genvar k = 0; k < 3; k++) begin : g_axis
      logic signed [CW:0] d;
      assign d = (CW+1)'(crd[e*3+k]) - (CW+1)'(crd[((e+1)%3)*3+k]);
      assign dif_d[e*3+k] = d[CW] ? CW'(-d) : CW'(d);
    end

    dtt_isqrt #(.CW(CW)) u_isqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  (rad_q[e]),
      .root_o (len[e])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dif_q <= dif_d;
      for (int i = 0; i < 9; i++) begin
        sq_q[i] <= dif_q[i] * dif_q[i];
      end
      for (int e = 0; e < 3; e++) begin
        rad_q[e] <= SW'(sq_q[e*3]) + SW'(sq_q[e*3+1]) + SW'(sq_q[e*3+2]);
      end
    end
  end

  dtt_heron #(.CW(CW), .FRAC(FRAC_BITS)) u_heron (
    .clk_i          (clk_i),
    .en_i           (en),
    .thr_i          (ratio_q),
    .a_i            (len[0]),
    .b_i            (len[1]),
    .c_i            (len[2]),
    .sliver_o       (out_o.is_sliver),
    .short_first_o  (out_o.short_first),
    .short_second_o (out_o.short_second),
    .longest_o      (out_o.longest_edge)
  );

endmodule

// File: sv/dtt_isqrt.sv
module dtt_isqrt #(
  parameter int CW = 32
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2*CW+1:0]    rad_i,
  output logic [CW+1:0]      root_o
);

  localparam int RW = CW + 2;
  localparam int W2 = 2 * RW;

  logic [RW-1:0] r_q   [RW];
  logic [W2-1:0] rem_q [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    localparam int KB = RW - 1 - g;
    logic [RW-1:0] r_in;
    logic [W2-1:0] rem_in;
    logic [W2-1:0] trial;
    logic [RW-1:0] r_d;
    logic [W2-1:0] rem_d;

    if (g == 0) begin : g_first
      assign r_in   = '0;
      assign rem_in = W2'(rad_i);
    end else begin : g_next
      assign r_in   = r_q[g-1];
      assign rem_in = rem_q[g-1];
    end

    always_comb begin
      trial = (W2'(r_in) << (KB + 1)) | (W2'(1) << (2 * KB));
      r_d   = r_in;
      rem_d = rem_in;
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        r_d   = r_in | (RW'(1) << KB);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[g]   <= r_d;
        rem_q[g] <= rem_d;
      end
    end
  end

  assign root_o = r_q[RW-1];

endmodule

// File: sv/dtt_heron.sv
module dtt_heron
  import dtt_pkg::*;
#(
  parameter int CW   = 32,
  parameter int FRAC = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [RatioWidth-1:0] thr_i,
  input  logic [CW+1:0]         a_i,
  input  logic [CW+1:0]         b_i,
  input  logic [CW+1:0]         c_i,
  output logic                  sliver_o,
  output logic [1:0]            short_first_o,
  output logic [1:0]            short_second_o,
  output logic [CW+1:0]         longest_o
);

  localparam int RW   = CW + 2;
  localparam int FW   = RW + 2;
  localparam int TW   = 2 * RatioWidth;
  localparam int PW   = 4 * FW;
  localparam int QW   = TW + 2 * RW;
  localparam int LSH  = 2 * RatioFrac;
  localparam int RSH  = 4 + 2 * FRAC;
  localparam int LHW  = PW + LSH;
  localparam int RHW  = QW + RSH;
  localparam int CMPW = (LHW > RHW) ? LHW : RHW;

  typedef struct packed {
    logic          neg;
    logic [RW-1:0] lng;
    logic [1:0]    sf;
    logic [1:0]    ss;
  } meta_t;

  meta_t meta_q [4];

  logic [FW-1:0] sum_q;
  logic [FW-1:0] f_q [3];
  logic [FW-1:0] sum_d;
  logic [FW-1:0] f_d [3];
  meta_t         meta_d;

  logic [FW-1:0] ab, ac, bc;
  logic          n1, n2, n3;

  always_comb begin
    bc = FW'(b_i) + FW'(c_i);
    ac = FW'(a_i) + FW'(c_i);
    ab = FW'(a_i) + FW'(b_i);
    sum_d = ab + FW'(c_i);
    n1 = bc < FW'(a_i);
    n2 = ac < FW'(b_i);
    n3 = ab < FW'(c_i);
    f_d[0] = n1 ? FW'(a_i) - bc : bc - FW'(a_i);
    f_d[1] = n2 ? FW'(b_i) - ac : ac - FW'(b_i);
    f_d[2] = n3 ? FW'(c_i) - ab : ab - FW'(c_i);
    meta_d.neg = n1 ^ n2 ^ n3;
    meta_d.lng = a_i;
    if (b_i > meta_d.lng) meta_d.lng = b_i;
    if (c_i > meta_d.lng) meta_d.lng = c_i;
    if (a_i <= b_i && a_i <= c_i) begin
      meta_d.sf = Vtx0;
      meta_d.ss = Vtx1;
    end else if (b_i <= c_i) begin
      meta_d.sf = Vtx1;
      meta_d.ss = Vtx2;
    end else begin
      meta_d.sf = Vtx2;
      meta_d.ss = Vtx0;
    end
  end

  logic [2*FW-1:0] m1_q, m2_q;
  logic [2*RW-1:0] ll_q;
  logic [TW-1:0]   tt_q;
  logic [2*FW-1:0] pp_q [4];
  logic [TW+RW-1:0] rr_lo_q, rr_hi_q;
  logic [PW-1:0]   p_q;
  logic [QW-1:0]   q_q;
  logic [PW-1:0]   p_d;
  logic [QW-1:0]   q_d;
  logic            sliver_q;
  logic            sliver_d;
  logic [CMPW-1:0] lhs, rhs;

  always_comb begin
    p_d = PW'(pp_q[0]) + (PW'(pp_q[1]) << FW) + (PW'(pp_q[2]) << FW)
        + (PW'(pp_q[3]) << (2 * FW));
    if (meta_q[2].neg) p_d = '0;
    q_d = QW'(rr_lo_q) + (QW'(rr_hi_q) << RW);
    lhs = CMPW'(p_q) << LSH;
    rhs = CMPW'(q_q) << RSH;
    sliver_d = (meta_q[3].lng == '0) || (lhs < rhs);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q     <= sum_d;
      f_q       <= f_d;
      meta_q[0] <= meta_d;

      m1_q      <= sum_q * f_q[0];
      m2_q      <= f_q[1] * f_q[2];
      ll_q      <= meta_q[0].lng * meta_q[0].lng;
      tt_q      <= thr_i * thr_i;
      meta_q[1] <= meta_q[0];

      pp_q[0]   <= m1_q[FW-1:0] * m2_q[FW-1:0];
      pp_q[1]   <= m1_q[FW-1:0] * m2_q[2*FW-1:FW];
      pp_q[2]   <= m1_q[2*FW-1:FW] * m2_q[FW-1:0];
      pp_q[3]   <= m1_q[2*FW-1:FW] * m2_q[2*FW-1:FW];
      rr_lo_q   <= tt_q * ll_q[RW-1:0];
      rr_hi_q   <= tt_q * ll_q[2*RW-1:RW];
      meta_q[2] <= meta_q[1];

      p_q       <= p_d;
      q_q       <= q_d;
      meta_q[3] <= meta_q[2];

      sliver_q  <= sliver_d;
    end
  end

  logic [RW-1:0] lng_out_q;
  logic [1:0]    sf_out_q, ss_out_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lng_out_q <= meta_q[3].lng;
      sf_out_q  <= meta_q[3].sf;
      ss_out_q  <= meta_q[3].ss;
    end
  end

  assign sliver_o       = sliver_q;
  assign short_first_o  = sf_out_q;
  assign short_second_o = ss_out_q;
  assign longest_o      = lng_out_q;

endmodule
